// ===== rtl/stto_pkg.sv =====
package stto_pkg;

	// field and datapath widths
	localparam int CW = 16;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	localparam int WW = 56;
	localparam int HW = WW / 2;
	localparam int XW = 2 * WW;

	// pipeline depth from request to result
	localparam int NSTAGE = 10;

	localparam logic [CW-1:0] RADIUS_RESET = 16'd256;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;
	typedef logic signed [WW-1:0] wide_t;
	typedef logic signed [XW-1:0] xw_t;

	localparam xw_t XZERO = '0;

	// cyclic neighbors of a vector component, also the opposite vertex of an edge
	localparam int NEXT_IDX [3] = '{1, 2, 0};
	localparam int PREV_IDX [3] = '{2, 0, 1};

	// one request as it enters the pipeline
	typedef struct {
		coord_t ctr [3];
		coord_t a [3];
		coord_t b [3];
		coord_t c [3];
	} in_t;

	// front end result: small dots, normal, edge terms
	typedef struct {
		diff_t v [3][3];
		diff_t ed [3][3];
		sum_t nv [3];
		sum_t pp [3];
		sum_t dv [3];
		sum_t e [3];
		sum_t d [3];
		sum_t rr;
	} front_t;

	// middle result: wide operands for the squared tests
	typedef struct {
		wide_t dpl;
		wide_t rv [3];
		wide_t qe [3][3];
		wide_t qo [3][3];
		wide_t re [3];
		logic vsep;
	} mid_t;

endpackage

// ===== rtl/stto_wmul.sv =====
module stto_wmul (
	input logic clk,
	input logic en,
	input stto_pkg::wide_t a,
	input stto_pkg::wide_t b,
	output stto_pkg::xw_t p
);
	import stto_pkg::*;

	logic signed [HW-1:0] ah, bh;
	logic signed [HW:0] al, bl;
	logic signed [2*HW-1:0] p11_s1, p11_s2;
	logic signed [2*HW:0] p10_s1, p01_s1;
	logic [2*HW-1:0] p00_s1, p00_s2;
	logic signed [2*HW+1:0] cross_s2;

	// split into signed high half and unsigned low half
	assign ah = a[WW-1:HW];
	assign bh = b[WW-1:HW];
	assign al = $signed({1'b0, a[HW-1:0]});
	assign bl = $signed({1'b0, b[HW-1:0]});

	// first stage: four half-width partial products
	always_ff @(posedge clk) begin
		if (en) begin
			p11_s1 <= (2*HW)'(ah) * (2*HW)'(bh);
			p10_s1 <= (2*HW+1)'(ah) * (2*HW+1)'(bl);
			p01_s1 <= (2*HW+1)'(al) * (2*HW+1)'(bh);
			p00_s1 <= (2*HW)'(a[HW-1:0]) * (2*HW)'(b[HW-1:0]);
		end
	end

	// second stage: merge the cross terms
	always_ff @(posedge clk) begin
		if (en) begin
			cross_s2 <= (2*HW+2)'(p10_s1) + (2*HW+2)'(p01_s1);
			p11_s2 <= p11_s1;
			p00_s2 <= p00_s1;
		end
	end

	// third stage: outer terms sit side by side, add the shifted cross term
	always_ff @(posedge clk) begin
		if (en) begin
			p <= xw_t'($signed({p11_s2, p00_s2})) + (xw_t'(cross_s2) <<< HW);
		end
	end

endmodule

// ===== rtl/stto_front.sv =====
module stto_front (
	input logic clk,
	input logic en,
	input stto_pkg::in_t in_d,
	input logic [stto_pkg::CW-1:0] radius,
	output stto_pkg::front_t f_s3
);
	import stto_pkg::*;

	diff_t r_sx;
	diff_t v_s1 [3][3];
	diff_t ed_s1 [3][3];
	diff_t ac_s1 [3];
	diff_t v_s2 [3][3];
	diff_t ed_s2 [3][3];
	prod_t sq_s2 [3][3];
	prod_t x_s2 [3][3];
	prod_t ee_s2 [3][3];
	prod_t de_s2 [3][3];
	prod_t np_s2 [3][2];
	prod_t rr_s2;

	assign r_sx = $signed({1'b0, radius});

	// vertices relative to the center, edge vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[0][i] <= diff_t'(in_d.a[i]) - diff_t'(in_d.ctr[i]);
				v_s1[1][i] <= diff_t'(in_d.b[i]) - diff_t'(in_d.ctr[i]);
				v_s1[2][i] <= diff_t'(in_d.c[i]) - diff_t'(in_d.ctr[i]);
				ed_s1[0][i] <= diff_t'(in_d.b[i]) - diff_t'(in_d.a[i]);
				ed_s1[1][i] <= diff_t'(in_d.c[i]) - diff_t'(in_d.b[i]);
				ed_s1[2][i] <= diff_t'(in_d.a[i]) - diff_t'(in_d.c[i]);
				ac_s1[i] <= diff_t'(in_d.c[i]) - diff_t'(in_d.a[i]);
			end
		end
	end

	// component products of all small dot and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s2[k][i] <= prod_t'(v_s1[k][i]) * prod_t'(v_s1[k][i]);
					ee_s2[k][i] <= prod_t'(ed_s1[k][i]) * prod_t'(ed_s1[k][i]);
					de_s2[k][i] <= prod_t'(v_s1[k][i]) * prod_t'(ed_s1[k][i]);
				end
				x_s2[0][i] <= prod_t'(v_s1[0][i]) * prod_t'(v_s1[1][i]);
				x_s2[1][i] <= prod_t'(v_s1[0][i]) * prod_t'(v_s1[2][i]);
				x_s2[2][i] <= prod_t'(v_s1[1][i]) * prod_t'(v_s1[2][i]);
				np_s2[i][0] <= prod_t'(ed_s1[0][NEXT_IDX[i]]) * prod_t'(ac_s1[PREV_IDX[i]]);
				np_s2[i][1] <= prod_t'(ed_s1[0][PREV_IDX[i]]) * prod_t'(ac_s1[NEXT_IDX[i]]);
			end
			rr_s2 <= prod_t'(r_sx) * prod_t'(r_sx);
			v_s2 <= v_s1;
			ed_s2 <= ed_s1;
		end
	end

	// sum the components
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				f_s3.nv[k] <= sum_t'(np_s2[k][0]) - sum_t'(np_s2[k][1]);
				f_s3.pp[k] <= sum_t'(sq_s2[k][0]) + sum_t'(sq_s2[k][1]) + sum_t'(sq_s2[k][2]);
				f_s3.dv[k] <= sum_t'(x_s2[k][0]) + sum_t'(x_s2[k][1]) + sum_t'(x_s2[k][2]);
				f_s3.e[k] <= sum_t'(ee_s2[k][0]) + sum_t'(ee_s2[k][1]) + sum_t'(ee_s2[k][2]);
				f_s3.d[k] <= sum_t'(de_s2[k][0]) + sum_t'(de_s2[k][1]) + sum_t'(de_s2[k][2]);
			end
			f_s3.rr <= sum_t'(rr_s2);
			f_s3.v <= v_s2;
			f_s3.ed <= ed_s2;
		end
	end

endmodule

// ===== rtl/stto_mid.sv =====
module stto_mid (
	input logic clk,
	input logic en,
	input stto_pkg::front_t f_s3,
	input logic [stto_pkg::CW-1:0] radius,
	output stto_pkg::mid_t m_s5
);
	import stto_pkg::*;

	diff_t r_sx;
	logic vsep;
	logic vsep_s4;
	wide_t dp_s4 [3];
	wide_t rv_s4 [3];
	wide_t re_s4 [3];
	wide_t pe_s4 [3][3];
	wide_t edd_s4 [3][3];
	wide_t se_s4 [3][3];

	assign r_sx = $signed({1'b0, radius});

	// vertex tests: outside the sphere and beyond both other vertices
	always_comb begin
		vsep = (f_s3.pp[0] > f_s3.rr && f_s3.dv[0] > f_s3.pp[0] && f_s3.dv[1] > f_s3.pp[0])
			|| (f_s3.pp[1] > f_s3.rr && f_s3.dv[0] > f_s3.pp[1] && f_s3.dv[2] > f_s3.pp[1])
			|| (f_s3.pp[2] > f_s3.rr && f_s3.dv[1] > f_s3.pp[2] && f_s3.dv[2] > f_s3.pp[2]);
	end

	// plane and edge products
	always_ff @(posedge clk) begin
		if (en) begin
			vsep_s4 <= vsep;
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= wide_t'(f_s3.v[0][i]) * wide_t'(f_s3.nv[i]);
				rv_s4[i] <= wide_t'(r_sx) * wide_t'(f_s3.nv[i]);
			end
			for (int k = 0; k < 3; k++) begin
				re_s4[k] <= wide_t'(r_sx) * wide_t'(f_s3.e[k]);
				for (int i = 0; i < 3; i++) begin
					pe_s4[k][i] <= wide_t'(f_s3.v[k][i]) * wide_t'(f_s3.e[k]);
					edd_s4[k][i] <= wide_t'(f_s3.ed[k][i]) * wide_t'(f_s3.d[k]);
					se_s4[k][i] <= wide_t'(f_s3.v[PREV_IDX[k]][i]) * wide_t'(f_s3.e[k]);
				end
			end
		end
	end

	// plane distance, closest edge point and its offset to the opposite vertex
	always_ff @(posedge clk) begin
		if (en) begin
			m_s5.vsep <= vsep_s4;
			m_s5.dpl <= dp_s4[0] + dp_s4[1] + dp_s4[2];
			m_s5.rv <= rv_s4;
			m_s5.re <= re_s4;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					m_s5.qe[k][i] <= pe_s4[k][i] - edd_s4[k][i];
					m_s5.qo[k][i] <= se_s4[k][i] - pe_s4[k][i] + edd_s4[k][i];
				end
			end
		end
	end

endmodule

// ===== rtl/stto_back.sv =====
module stto_back (
	input logic clk,
	input logic en,
	input stto_pkg::mid_t m_s5,
	output logic overlaps_s10
);
	import stto_pkg::*;

	xw_t dd_s8;
	xw_t rv2_s8 [3];
	xw_t qq_s8 [3][3];
	xw_t qo2_s8 [3][3];
	xw_t re2_s8 [3];
	logic vsep_s6, vsep_s7, vsep_s8, vsep_s9;
	xw_t dd_s9, pr_s9;
	xw_t eqq_s9 [3];
	xw_t eqo_s9 [3];
	xw_t ere_s9 [3];
	logic esep, sep;

	// wide squares and dot terms
	stto_wmul u_dd (.clk(clk), .en(en), .a(m_s5.dpl), .b(m_s5.dpl), .p(dd_s8));

	genvar gk, gi;
	generate
		for (gk = 0; gk < 3; gk++) begin : g_edge
			stto_wmul u_re (.clk(clk), .en(en), .a(m_s5.re[gk]), .b(m_s5.re[gk]),
				.p(re2_s8[gk]));
			stto_wmul u_rv (.clk(clk), .en(en), .a(m_s5.rv[gk]), .b(m_s5.rv[gk]),
				.p(rv2_s8[gk]));
			for (gi = 0; gi < 3; gi++) begin : g_comp
				stto_wmul u_qq (.clk(clk), .en(en), .a(m_s5.qe[gk][gi]),
					.b(m_s5.qe[gk][gi]), .p(qq_s8[gk][gi]));
				stto_wmul u_qo (.clk(clk), .en(en), .a(m_s5.qe[gk][gi]),
					.b(m_s5.qo[gk][gi]), .p(qo2_s8[gk][gi]));
			end
		end
	endgenerate

	// vertex result follows the multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			vsep_s6 <= m_s5.vsep;
			vsep_s7 <= vsep_s6;
			vsep_s8 <= vsep_s7;
		end
	end

	// sum the dot products
	always_ff @(posedge clk) begin
		if (en) begin
			vsep_s9 <= vsep_s8;
			dd_s9 <= dd_s8;
			pr_s9 <= rv2_s8[0] + rv2_s8[1] + rv2_s8[2];
			for (int k = 0; k < 3; k++) begin
				eqq_s9[k] <= qq_s8[k][0] + qq_s8[k][1] + qq_s8[k][2];
				eqo_s9[k] <= qo2_s8[k][0] + qo2_s8[k][1] + qo2_s8[k][2];
				ere_s9[k] <= re2_s8[k];
			end
		end
	end

	// edge tests: closest edge point outside the sphere and opposite vertex beyond it
	always_comb begin
		esep = 1'b0;
		for (int k = 0; k < 3; k++) begin
			esep = esep || (eqq_s9[k] > ere_s9[k] && eqo_s9[k] > XZERO);
		end
		sep = vsep_s9 || (dd_s9 > pr_s9) || esep;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			overlaps_s10 <= !sep;
		end
	end

endmodule

// ===== rtl/sphere_triangle_overlap_test.sv =====
// an accepted request passes the front, middle and back sections into the output register
// throughput: one request per cycle; the whole pipeline holds while a result waits
// the depth is set by the three-stage split wide multipliers behind the plane and edge tests
// reset clears all stage valid bits and sets the radius to 1.0 (256 in Q8.8)
module sphere_triangle_overlap_test (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input stto_pkg::coord_t center_x,
	input stto_pkg::coord_t center_y,
	input stto_pkg::coord_t center_z,
	input stto_pkg::coord_t a_x,
	input stto_pkg::coord_t a_y,
	input stto_pkg::coord_t a_z,
	input stto_pkg::coord_t b_x,
	input stto_pkg::coord_t b_y,
	input stto_pkg::coord_t b_z,
	input stto_pkg::coord_t c_x,
	input stto_pkg::coord_t c_y,
	input stto_pkg::coord_t c_z,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [stto_pkg::CW-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic overlaps
);
	import stto_pkg::*;

	logic en;
	logic [NSTAGE-1:0] vld_q;
	logic [CW-1:0] radius_q;
	in_t in_d;
	front_t f_s3;
	mid_t m_s5;
	logic overlaps_s10;

	// radius register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// pipeline advances unless the finished result is still waiting
	assign en = !vld_q[NSTAGE-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[NSTAGE-1];
	assign overlaps = overlaps_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	// request fields
	assign in_d.ctr[0] = center_x;
	assign in_d.ctr[1] = center_y;
	assign in_d.ctr[2] = center_z;
	assign in_d.a[0] = a_x;
	assign in_d.a[1] = a_y;
	assign in_d.a[2] = a_z;
	assign in_d.b[0] = b_x;
	assign in_d.b[1] = b_y;
	assign in_d.b[2] = b_z;
	assign in_d.c[0] = c_x;
	assign in_d.c[1] = c_y;
	assign in_d.c[2] = c_z;

	stto_front u_front (
		.clk(clk),
		.en(en),
		.in_d(in_d),
		.radius(radius_q),
		.f_s3(f_s3)
	);

	stto_mid u_mid (
		.clk(clk),
		.en(en),
		.f_s3(f_s3),
		.radius(radius_q),
		.m_s5(m_s5)
	);

	stto_back u_back (
		.clk(clk),
		.en(en),
		.m_s5(m_s5),
		.overlaps_s10(overlaps_s10)
	);

	// an accepted request occupies the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted request missing from first stage");

	// a held pipeline keeps its occupancy
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("stage valid bits moved during stall");

	// stall only comes from a waiting result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a waiting result");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import stto_pkg::*;

	localparam int LATENCY = stto_pkg::NSTAGE;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int RANDOM_ITEMS = 950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t center_x = '0, center_y = '0, center_z = '0;
	coord_t a_x = '0, a_y = '0, a_z = '0;
	coord_t b_x = '0, b_y = '0, b_z = '0;
	coord_t c_x = '0, c_y = '0, c_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CW-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic overlaps;

	// one triangle query, with a typed expectation where obvious
	typedef struct {
		coord_t ctr [3];
		coord_t a [3];
		coord_t b [3];
		coord_t c [3];
		int known;
	} query_t;

	sphere_triangle_overlap_test dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .overlaps(overlaps)
	);

	always #6 clk = ~clk;

	logic [15:0] radius_q;
	bit overlap_q [$];
	int fails = 0;
	int cycles = 0;

	// exact overlap predictor, 256-bit signed arithmetic throughout
	typedef logic signed [255:0] big_t;

	function automatic big_t dot3(big_t p [3], big_t q [3]);
		return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
	endfunction

	function automatic bit vert_apart(big_t p [3], big_t q [3], big_t s [3], big_t rr);
		big_t pp;
		pp = dot3(p, p);
		return pp > rr && dot3(p, q) > pp && dot3(p, s) > pp;
	endfunction

	function automatic bit edge_apart(big_t p [3], big_t q [3], big_t s [3], big_t r);
		big_t ed [3], qe [3], qo [3];
		big_t e, d, re;
		for (int i = 0; i < 3; i++) ed[i] = q[i] - p[i];
		e = dot3(ed, ed);
		d = dot3(p, ed);
		for (int i = 0; i < 3; i++) qe[i] = p[i] * e - ed[i] * d;
		for (int i = 0; i < 3; i++) qo[i] = s[i] * e - qe[i];
		re = r * e;
		return dot3(qe, qe) > re * re && dot3(qe, qo) > 0;
	endfunction

	function automatic bit sphere_hits(query_t t, logic [15:0] rad);
		big_t va [3], vb [3], vc [3], ab [3], ac [3], nv [3], rv [3];
		big_t r, rr, dpl;
		bit apart;
		for (int i = 0; i < 3; i++) begin
			va[i] = big_t'(t.a[i]) - big_t'(t.ctr[i]);
			vb[i] = big_t'(t.b[i]) - big_t'(t.ctr[i]);
			vc[i] = big_t'(t.c[i]) - big_t'(t.ctr[i]);
			ab[i] = vb[i] - va[i];
			ac[i] = vc[i] - va[i];
		end
		r = big_t'({1'b0, rad});
		rr = r * r;
		nv[0] = ab[1] * ac[2] - ab[2] * ac[1];
		nv[1] = ab[2] * ac[0] - ab[0] * ac[2];
		nv[2] = ab[0] * ac[1] - ab[1] * ac[0];
		for (int i = 0; i < 3; i++) rv[i] = r * nv[i];
		dpl = dot3(va, nv);
		apart = dpl * dpl > dot3(rv, rv);
		apart = apart || vert_apart(va, vb, vc, rr);
		apart = apart || vert_apart(vb, va, vc, rr);
		apart = apart || vert_apart(vc, va, vb, rr);
		apart = apart || edge_apart(va, vb, vc, r);
		apart = apart || edge_apart(vb, vc, va, r);
		apart = apart || edge_apart(vc, va, vb, r);
		return !apart;
	endfunction

	// result checker and random stall on the output
	int out_wait = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (overlap_q.size() == 0) begin
				$error("overlaps: no result expected, actual %0d", overlaps);
				fails++;
			end else begin
				if (overlaps !== overlap_q[0]) begin
					$error("overlaps: expected %0d actual %0d", overlap_q[0], overlaps);
					fails++;
				end
				void'(overlap_q.pop_front());
			end
		end
		if (arst_n) begin
			if (out_wait > 0) begin
				out_wait <= out_wait - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				if ($urandom_range(0, 3) == 0) begin
					out_wait <= $urandom_range(0, 13);
					out_ready <= 1'b0;
				end
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic write_radius(logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radius_q = val;
	endtask

	task automatic drain_all();
		while (overlap_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// idle gap before the request, then hold it until accepted
	task automatic send_query(query_t t, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= t.ctr[0]; center_y <= t.ctr[1]; center_z <= t.ctr[2];
		a_x <= t.a[0]; a_y <= t.a[1]; a_z <= t.a[2];
		b_x <= t.b[0]; b_y <= t.b[1]; b_z <= t.b[2];
		c_x <= t.c[0]; c_y <= t.c[1]; c_z <= t.c[2];
		do @(posedge clk); while (!in_ready);
		if (t.known >= 0 && t.known != int'(sphere_hits(t, radius_q))) begin
			$error("overlaps: table expected %0d predictor %0d", t.known,
				sphere_hits(t, radius_q));
			fails++;
		end
		overlap_q.push_back(sphere_hits(t, radius_q));
	endtask

	function automatic query_t make_tri(int cx, int cy, int cz, int ax, int ay, int az,
			int bx, int by, int bz, int qx, int qy, int qz, int known);
		query_t t;
		t.ctr = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
		t.a = '{coord_t'(ax), coord_t'(ay), coord_t'(az)};
		t.b = '{coord_t'(bx), coord_t'(by), coord_t'(bz)};
		t.c = '{coord_t'(qx), coord_t'(qy), coord_t'(qz)};
		t.known = known;
		return t;
	endfunction

	// random coordinate: near a spot with mostly small spread, sometimes full range
	function automatic coord_t near(int base, int spread);
		int v;
		if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
		v = base + $signed($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return coord_t'(v);
	endfunction

	function automatic query_t rand_query();
		query_t t;
		int bx, by, bz, sp;
		bx = $signed($urandom_range(0, 65535)) - 32768;
		by = $signed($urandom_range(0, 65535)) - 32768;
		bz = $signed($urandom_range(0, 65535)) - 32768;
		sp = (1 << $urandom_range(4, 14));
		t.ctr = '{near(bx, sp), near(by, sp), near(bz, sp)};
		t.a = '{near(bx, sp), near(by, sp), near(bz, sp)};
		t.b = '{near(bx, sp), near(by, sp), near(bz, sp)};
		if ($urandom_range(0, 7) == 0) t.c = t.b;
		else t.c = '{near(bx, sp), near(by, sp), near(bz, sp)};
		t.known = -1;
		return t;
	endfunction

	query_t dir_rows [$];
	logic [15:0] radius_set [5] = '{16'd0, 16'd65535, 16'd1, 16'd4096, 16'd300};

	initial begin
		radius_q = RADIUS_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset radius of 1.0
		dir_rows.push_back(make_tri(0, 0, 0, -256, -256, 0, 256, -256, 0, 0, 256, 0, 1));
		dir_rows.push_back(make_tri(0, 0, 1024, -256, -256, 0, 256, -256, 0, 0, 256, 0, 0));
		dir_rows.push_back(make_tri(0, 0, 256, -256, -256, 0, 256, -256, 0, 0, 256, 0, 1));
		dir_rows.push_back(make_tri(0, 0, 0, 512, 0, 0, 1024, 0, 0, 512, 512, 0, 0));
		dir_rows.push_back(make_tri(0, 0, 0, 256, 0, 0, 1024, 0, 0, 512, 512, 0, 1));
		dir_rows.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(make_tri(0, 0, 0, -1024, 512, 0, 1024, 512, 0, 0, 2048, 0, 0));
		dir_rows.push_back(make_tri(0, 0, 0, -1024, 200, 0, 1024, 200, 0, 0, 2048, 0, 1));
		dir_rows.push_back(make_tri(0, 0, 0, -512, 0, 0, 512, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(make_tri(0, 0, 0, 0, 1024, 0, 0, 2048, 0, 0, 4096, 0, 0));
		dir_rows.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
			32767, -32768, 32767, -32768, 32767, 32767, 0));
		dir_rows.push_back(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, -32768, -32768, 32767, -32768, 0));
		dir_rows.push_back(make_tri(0, 0, 0, -32768, -32768, 0, 32767, -32768, 0,
			0, 32767, 0, 1));
		dir_rows.push_back(make_tri(-1, 21845, -21846, 12345, -4321, 32767, -32768,
			1, -2, 7, 8, 9, -1));
		foreach (dir_rows[i]) send_query(dir_rows[i], $urandom_range(0, 2));
		in_valid <= 1'b0;
		drain_all();

		// phases across radius settings, edge settings included
		foreach (radius_set[p]) begin
			write_radius(radius_set[p]);
			if (p == 0) send_query(make_tri(256, 0, 0, 256, 0, 0, 0, 0, 0, 0, 256, 0, 1), 0);
			if (p == 1) send_query(make_tri(0, 0, 0, -32768, -32768, -32768,
				32767, -32768, -32768, 0, 32767, -32768, 1), 0);
			for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
				if (n % 64 < 40) send_query(rand_query(), 0);
				else send_query(rand_query(), $urandom_range(0, 13));
				if (n == 100) begin
					in_valid <= 1'b0;
					while (overlap_q.size() != 0) @(posedge clk);
				end
			end
			in_valid <= 1'b0;
			drain_all();
		end

		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
